>>> rtl/trdd_pkg.sv
// ----------------------------------------------------------------------------
// trdd_pkg
// Shared types, tablet type codes and format tables for the tablet record
// deframer and decoder.
// ----------------------------------------------------------------------------
package trdd_pkg;

  localparam int MAX_RECORD = 17;
  localparam int FILL_W     = $clog2(MAX_RECORD + 1);
  localparam int IDX_W      = $clog2(MAX_RECORD);

  typedef logic [3:0] ttype_t;

  // Tablet type codes.
  localparam ttype_t TT_NONE        = 4'd0;
  localparam ttype_t TT_LOWRES_A    = 4'd1;
  localparam ttype_t TT_LOWRES_B    = 4'd2;
  localparam ttype_t TT_PRESSURE    = 4'd3;
  localparam ttype_t TT_TRACKER     = 4'd4;
  localparam ttype_t TT_NEWLOW_PROX = 4'd5;
  localparam ttype_t TT_HIRES_PROX  = 4'd6;
  localparam ttype_t TT_NEWLOW      = 4'd7;
  localparam ttype_t TT_HIRES       = 4'd8;
  localparam ttype_t TT_RESET       = TT_LOWRES_B;

  localparam logic [6:0]  KEY_SPACE = 7'o040;
  localparam logic [15:0] INPROX    = 16'h8000;

  typedef logic [6:0] rbyte_t;
  typedef rbyte_t [MAX_RECORD-1:0] rec_buf_t;

  // Deframer status toward the result stage.
  typedef struct packed {
    logic              pend;
    ttype_t            ttype;
    logic [FILL_W-1:0] fill;
  } frm_stat_t;

  typedef struct packed {
    logic [20:0] x_position;
    logic [20:0] y_position;
    logic [15:0] z_position;
    logic [15:0] azimuth;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [15:0] status_word;
    logic [6:0]  key_code;
    logic [4:0]  pen_pressure;
    logic [6:0]  x_tilt;
    logic [6:0]  y_tilt;
    logic [15:0] sample_count;
  } result_t;

  // Record length per tablet type; zero means the type ignores input.
  function automatic logic [FILL_W-1:0] rec_len(ttype_t t);
    logic [FILL_W-1:0] len;
    unique case (t)
      TT_LOWRES_A, TT_LOWRES_B, TT_NEWLOW_PROX, TT_NEWLOW: len = FILL_W'(5);
      TT_HIRES_PROX, TT_HIRES:                              len = FILL_W'(6);
      TT_PRESSURE:                                          len = FILL_W'(8);
      TT_TRACKER:                                           len = FILL_W'(17);
      default:                                              len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] sync_mask(ttype_t t);
    logic [7:0] m;
    unique case (t)
      TT_NEWLOW_PROX, TT_NEWLOW: m = 8'o100;
      TT_LOWRES_A, TT_LOWRES_B, TT_PRESSURE, TT_TRACKER,
      TT_HIRES_PROX, TT_HIRES:   m = 8'o200;
      default:                   m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/trdd_if.sv
// ----------------------------------------------------------------------------
// trdd channel interfaces
// Valid/ready channels for received bytes and for decoded records.
// ----------------------------------------------------------------------------
interface trdd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface trdd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] x_position;
  logic [20:0] y_position;
  logic [15:0] z_position;
  logic [15:0] azimuth;
  logic [15:0] pitch;
  logic [15:0] roll;
  logic [15:0] status_word;
  logic [6:0]  key_code;
  logic [4:0]  pen_pressure;
  logic [6:0]  x_tilt;
  logic [6:0]  y_tilt;
  logic [15:0] sample_count;

  modport source (output valid, output x_position, output y_position, output z_position,
                  output azimuth, output pitch, output roll, output status_word,
                  output key_code, output pen_pressure, output x_tilt, output y_tilt,
                  output sample_count, input ready);
  modport sink   (input valid, input x_position, input y_position, input z_position,
                  input azimuth, input pitch, input roll, input status_word,
                  input key_code, input pen_pressure, input x_tilt, input y_tilt,
                  input sample_count, output ready);
endinterface

>>> rtl/trdd_deframer.sv
// ----------------------------------------------------------------------------
// trdd_deframer
// Stores received bytes into the record buffer, tracks the fill count and
// flags a complete record until the result stage takes it.
// ----------------------------------------------------------------------------
module trdd_deframer import trdd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_acc,
  input  logic [7:0] rx_byte,
  input  ttype_t     tablet_type,
  input  logic       advance,
  output rec_buf_t   rec_buf,
  output frm_stat_t  stat
);

  rec_buf_t          buf_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              pend_r;
  logic              pend_nxt;
  ttype_t            ptype_r;

  logic [FILL_W-1:0] len;
  logic              active;
  logic              restart;
  logic [FILL_W-1:0] idx;
  logic              complete;
  logic              wr_en;

  always_comb begin
    len      = rec_len(tablet_type);
    active   = (len != '0);
    // A sync bit or a byte past a full record starts a new record.
    restart  = ((rx_byte & sync_mask(tablet_type)) != 8'h00) || (fill_r >= len);
    idx      = restart ? '0 : fill_r;
    fill_nxt = idx + FILL_W'(1);
    complete = byte_acc && active && (fill_nxt == len);
    wr_en    = byte_acc && active && (idx < FILL_W'(MAX_RECORD));
    if (complete) begin
      pend_nxt = 1'b1;
    end else if (advance) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      if (byte_acc && active) begin
        fill_r <= fill_nxt;
      end
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[idx[IDX_W-1:0]] <= rx_byte[6:0];
    end
    if (complete) begin
      ptype_r <= tablet_type;
    end
  end

  assign rec_buf    = buf_r;
  assign stat.pend  = pend_r;
  assign stat.ttype = ptype_r;
  assign stat.fill  = fill_r;

endmodule

>>> rtl/trdd_decoder.sv
// ----------------------------------------------------------------------------
// trdd_decoder
// Slices a completed record into the result fields for its tablet format.
// ----------------------------------------------------------------------------
module trdd_decoder import trdd_pkg::*; (
  input  rec_buf_t    rec_buf,
  input  ttype_t      ttype,
  input  logic [6:0]  held_key,
  input  logic [15:0] sample_cnt,
  output result_t     res,
  output logic [6:0]  key_nxt
);

  logic [5:0]  v;
  logic [13:0] x14;
  logic [15:0] st;
  logic [4:0]  p;

  always_comb begin
    res         = '0;
    key_nxt     = held_key;
    v           = rec_buf[0][5:0];
    x14         = {rec_buf[1], rec_buf[2]};
    st          = '0;
    p           = rec_buf[0][6:2];
    unique case (ttype)
      TT_LOWRES_A, TT_LOWRES_B: begin
        st = rec_buf[0][6] ? INPROX : 16'h0000;
        // The button code starts at 037; codes from 040 up map two to a bit.
        if (v == 6'o37) begin
          st[0] = 1'b1;
        end else if (v > 6'o37) begin
          st[v[4:1]] = 1'b1;
        end
        if (x14 < 14'd256) begin
          st[15] = 1'b0;
        end
        res.x_position  = 21'(x14);
        res.y_position  = 21'({rec_buf[3], rec_buf[4]});
        res.status_word = st;
      end
      TT_PRESSURE: begin
        res.pen_pressure = p;
        res.status_word  = INPROX | 16'(p > 5'd16);
        res.x_position   = 21'({rec_buf[0][1:0], rec_buf[1], rec_buf[2]});
        res.y_position   = 21'({rec_buf[3][1:0], rec_buf[4], rec_buf[5]});
        res.x_tilt       = rec_buf[6];
        res.y_tilt       = rec_buf[7];
      end
      TT_TRACKER: begin
        // Each axis takes its top two bits from a shared extension byte.
        res.x_position  = 21'({rec_buf[9][1:0], rec_buf[3], rec_buf[4]});
        res.y_position  = 21'({rec_buf[9][3:2], rec_buf[5], rec_buf[6]});
        res.z_position  = {rec_buf[9][5:4], rec_buf[7], rec_buf[8]};
        res.azimuth     = {rec_buf[16][1:0], rec_buf[10], rec_buf[11]};
        res.pitch       = {rec_buf[16][3:2], rec_buf[12], rec_buf[13]};
        res.roll        = {rec_buf[16][5:4], rec_buf[14], rec_buf[15]};
        res.status_word = 16'({rec_buf[0], rec_buf[1]});
        if (rec_buf[2] != KEY_SPACE) begin
          key_nxt = rec_buf[2];
        end
        res.key_code = key_nxt;
      end
      TT_NEWLOW_PROX, TT_NEWLOW: begin
        res.status_word = INPROX | 16'(rec_buf[0][5:2]);
        // The two coordinate bytes overlap by one bit in this format.
        res.x_position  = 21'({6'b0, rec_buf[1]} | {rec_buf[2], 6'b0});
        res.y_position  = 21'({6'b0, rec_buf[3]} | {rec_buf[4], 6'b0});
      end
      TT_HIRES_PROX, TT_HIRES: begin
        res.x_position = 21'({rec_buf[0][1:0], rec_buf[1], rec_buf[2]});
        res.y_position = {rec_buf[3], rec_buf[4], rec_buf[5]};
        st = INPROX | 16'(p);
        if ((ttype == TT_HIRES_PROX) && p[4]) begin
          st[4]  = 1'b0;
          st[15] = 1'b0;
        end
        res.status_word = st;
      end
      default: begin
        res = '0;
      end
    endcase
    res.sample_count = sample_cnt + 16'd1;
  end

endmodule

>>> rtl/tablet_record_deframer_decoder_core.sv
// ----------------------------------------------------------------------------
// tablet_record_deframer_decoder_core
// Deframes serial tablet bytes into records and decodes each record.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while input is not held off. A byte that
// completes a record is stored in the record buffer and flagged pending; the
// decoder reads fixed buffer positions combinationally, and the result word
// is loaded into the output register once that register is free. Input is
// held off only while a decoded record waits behind a stalled output
// register. The tablet type register resets to 2; the user must write it
// only while no record is in flight, as the block does not enforce this.
// Types 0 and 9 to 15 consume bytes silently.
module tablet_record_deframer_decoder_core import trdd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_wdata,
  trdd_in_if.sink       in_ch,
  trdd_out_if.source    out_ch
);

  ttype_t      ttype_r;
  rec_buf_t    rec_buf;
  frm_stat_t   stat;
  result_t     dec_res;
  logic [6:0]  key_dec;

  result_t     res_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [15:0] cnt_r;
  logic [6:0]  key_r;

  logic        out_free;
  logic        load;
  logic        byte_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttype_r <= TT_RESET;
    end else if (cfg_we) begin
      ttype_r <= cfg_wdata;
    end
  end

  assign out_free     = !out_valid_r || out_ch.ready;
  assign load         = stat.pend && out_free;
  assign in_ch.ready  = !stat.pend || out_free;
  assign byte_acc     = in_ch.valid && in_ch.ready;

  trdd_deframer u_deframer (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_acc    (byte_acc),
    .rx_byte     (in_ch.rx_byte),
    .tablet_type (ttype_r),
    .advance     (load),
    .rec_buf     (rec_buf),
    .stat        (stat)
  );

  trdd_decoder u_decoder (
    .rec_buf    (rec_buf),
    .ttype      (stat.ttype),
    .held_key   (key_r),
    .sample_cnt (cnt_r),
    .res        (dec_res),
    .key_nxt    (key_dec)
  );

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      key_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        cnt_r <= dec_res.sample_count;
        key_r <= key_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= dec_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.x_position   = res_r.x_position;
  assign out_ch.y_position   = res_r.y_position;
  assign out_ch.z_position   = res_r.z_position;
  assign out_ch.azimuth      = res_r.azimuth;
  assign out_ch.pitch        = res_r.pitch;
  assign out_ch.roll         = res_r.roll;
  assign out_ch.status_word  = res_r.status_word;
  assign out_ch.key_code     = res_r.key_code;
  assign out_ch.pen_pressure = res_r.pen_pressure;
  assign out_ch.x_tilt       = res_r.x_tilt;
  assign out_ch.y_tilt       = res_r.y_tilt;
  assign out_ch.sample_count = res_r.sample_count;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fill <= FILL_W'(MAX_RECORD))
    else $error("fill count beyond record buffer");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.pend |-> in_ch.ready)
    else $error("input held off with no record waiting");

  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pend && out_ch.valid && !out_ch.ready |=> stat.pend)
    else $error("decoded record dropped while output stalled");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cnt_r == $past(cnt_r) + 16'd1)
    else $error("sample counter did not advance by one");
`endif

endmodule

>>> test/trdd_record_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trdd_record_check
// Watches the byte and record channels of the tablet deframer, rebuilds every
// decoded record from the accepted bytes and compares it field by field with
// the record words that the block hands out.
// ----------------------------------------------------------------------------
module trdd_record_check import trdd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  trdd_in_if         in_ch,
  trdd_out_if        out_ch,
  output int         mismatches,
  output int         records_due
);

  typedef logic [20:0] field_set_t [12];

  string field_name [12] = '{"x_position", "y_position", "z_position", "azimuth",
                             "pitch", "roll", "status_word", "key_code",
                             "pen_pressure", "x_tilt", "y_tilt", "sample_count"};

  rbyte_t      rec [MAX_RECORD];
  int          fill;
  logic [15:0] samples;
  rbyte_t      key;
  ttype_t      ttype;
  result_t     decoded_due [$];
  int          field_errors;

  function automatic logic [15:0] tracker_axis(int lo, int hi, int ext, rbyte_t m, int sh);
    logic [31:0] v;
    v = 32'(rec[lo]) | (32'(rec[hi]) << 7) | (32'(rec[ext] & m) << sh);
    return v[15:0];
  endfunction

  function automatic field_set_t split_fields(result_t r);
    field_set_t f;
    f = '{r.x_position, r.y_position, 21'(r.z_position), 21'(r.azimuth),
          21'(r.pitch), 21'(r.roll), 21'(r.status_word), 21'(r.key_code),
          21'(r.pen_pressure), 21'(r.x_tilt), 21'(r.y_tilt), 21'(r.sample_count)};
    return f;
  endfunction

  // Stores one accepted byte and, when it completes a record, queues the
  // decoded record word.
  task automatic deframe_byte(input logic [7:0] c);
    int          len;
    logic [7:0]  sm;
    result_t     r;
    rbyte_t      b0;
    rbyte_t      v;
    logic [15:0] st;
    logic [4:0]  p;
    case (ttype)
      TT_LOWRES_A, TT_LOWRES_B: begin len = 5;  sm = 8'o200; end
      TT_PRESSURE:              begin len = 8;  sm = 8'o200; end
      TT_TRACKER:               begin len = 17; sm = 8'o200; end
      TT_NEWLOW_PROX, TT_NEWLOW: begin len = 5; sm = 8'o100; end
      TT_HIRES_PROX, TT_HIRES:  begin len = 6;  sm = 8'o200; end
      default:                  begin len = 0;  sm = 8'h00;  end
    endcase
    if (len == 0) return;
    if ((c & sm) != 0 || fill >= len) fill = 0;
    rec[fill] = c[6:0];
    fill++;
    if (fill != len) return;

    r  = '0;
    b0 = rec[0];
    st = '0;
    case (ttype)
      TT_LOWRES_A, TT_LOWRES_B: begin
        v  = b0 & 7'o077;
        st = b0[6] ? INPROX : 16'h0000;
        // The first byte names one button: 037 is button zero, higher codes
        // select a bit two codes apart.
        if (v == 7'o037) st[0] = 1'b1;
        else if (v > 7'o037) st[(v - 7'o040) >> 1] = 1'b1;
        r.x_position = 21'({rec[1], rec[2]});
        r.y_position = 21'({rec[3], rec[4]});
        if (r.x_position < 21'd256) st[15] = 1'b0;
      end
      TT_PRESSURE: begin
        p              = b0[6:2];
        r.pen_pressure = p;
        st             = INPROX | 16'(p > 5'd16);
        r.x_position   = 21'({b0[1:0], rec[1], rec[2]});
        r.y_position   = 21'({rec[3][1:0], rec[4], rec[5]});
        r.x_tilt       = rec[6];
        r.y_tilt       = rec[7];
      end
      TT_TRACKER: begin
        r.x_position  = 21'(tracker_axis(4, 3, 9, 7'h03, 14));
        r.y_position  = 21'(tracker_axis(6, 5, 9, 7'h0C, 12));
        r.z_position  = tracker_axis(8, 7, 9, 7'h30, 10);
        r.azimuth     = tracker_axis(11, 10, 16, 7'h03, 14);
        r.pitch       = tracker_axis(13, 12, 16, 7'h0C, 12);
        r.roll        = tracker_axis(15, 14, 16, 7'h30, 10);
        st            = 16'({rec[0], rec[1]});
        if (rec[2] != KEY_SPACE) key = rec[2];
        r.key_code    = key;
      end
      TT_NEWLOW_PROX, TT_NEWLOW: begin
        st = INPROX | 16'(b0[5:2]);
        if (ttype == TT_NEWLOW_PROX && st[4]) begin
          st[4]  = 1'b0;
          st[15] = 1'b0;
        end
        r.x_position = 21'(rec[1]) | (21'(rec[2]) << 6);
        r.y_position = 21'(rec[3]) | (21'(rec[4]) << 6);
      end
      TT_HIRES_PROX, TT_HIRES: begin
        r.x_position = 21'({b0[1:0], rec[1], rec[2]});
        r.y_position = {rec[3], rec[4], rec[5]};
        st = INPROX | 16'(b0[6:2]);
        if (ttype == TT_HIRES_PROX && st[4]) begin
          st[4]  = 1'b0;
          st[15] = 1'b0;
        end
      end
      default: ;
    endcase
    samples        = samples + 16'd1;
    r.status_word  = st;
    r.sample_count = samples;
    decoded_due.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    result_t    want;
    field_set_t exp_f;
    field_set_t got_f;
    if (!rst_n) begin
      fill    = 0;
      samples = '0;
      key     = '0;
      ttype   = TT_RESET;
      foreach (rec[i]) rec[i] = '0;
      decoded_due.delete();
      field_errors = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_due.size() == 0) begin
          $display("%0t: record word with none expected, sample_count %0d",
                   $time, out_ch.sample_count);
          field_errors++;
        end else begin
          want  = decoded_due.pop_front();
          exp_f = split_fields(want);
          got_f = '{out_ch.x_position, out_ch.y_position, 21'(out_ch.z_position),
                    21'(out_ch.azimuth), 21'(out_ch.pitch), 21'(out_ch.roll),
                    21'(out_ch.status_word), 21'(out_ch.key_code),
                    21'(out_ch.pen_pressure), 21'(out_ch.x_tilt), 21'(out_ch.y_tilt),
                    21'(out_ch.sample_count)};
          foreach (exp_f[k]) begin
            if (exp_f[k] !== got_f[k]) begin
              $display("%0t: %s expected %0h actual %0h", $time, field_name[k],
                       exp_f[k], got_f[k]);
              field_errors++;
            end
          end
        end
      end
      if (cfg_we) ttype = cfg_wdata;
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.rx_byte);
    end
    mismatches  <= field_errors;
    records_due <= decoded_due.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the tablet deframer with framed records of every tablet type, broken
// records and loose noise bytes, switches the tablet type between phases and
// stalls the record channel at random; a separate checker judges each word.
// ----------------------------------------------------------------------------
module tb_top;
  import trdd_pkg::*;

  localparam int ITEMS         = 1050;
  localparam int LIMIT         = 200000;
  localparam int SQUEEZE_PHASE = 8;
  localparam int CALM_FIRST    = 4;
  localparam int CALM_LAST     = 7;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  logic       calm;
  logic       squeeze;
  logic       squeezed  = 1'b0;
  int         hold_left = 0;
  int         cyc       = 0;
  int         mismatches;
  int         records_due;
  int         fed;
  ttype_t     cur_type;

  trdd_in_if  in_ch ();
  trdd_out_if out_ch ();

  tablet_record_deframer_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  trdd_record_check check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .records_due (records_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Record receiver. One long hold-off lets the block fill up while bytes
  // keep coming.
  always @(posedge clk) begin
    if (squeeze && !squeezed) begin
      squeezed     <= 1'b1;
      hold_left    <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 26);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (rec_len(cur_type) != 0) fed++;
  endtask

  // Waits until every expected word is out and the block has gone quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (records_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_type(input ttype_t t);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_type  = t;
  endtask

  // A byte at a given position of a record: the head carries the sync bit,
  // every other byte has it cleared. Tracker keys are often a space.
  function automatic logic [7:0] framed(int pos, logic [7:0] sm, bit head);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (head) b = b | sm;
    else b = b & ~sm;
    if (cur_type == TT_TRACKER && pos == 2 && $urandom_range(3) == 0) b = KEY_SPACE;
    return b;
  endfunction

  initial begin : stimulus
    int         len;
    int         nrec;
    int         count;
    int         kind;
    logic [7:0] sm;
    ttype_t     t;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    calm          <= 1'b0;
    squeeze       <= 1'b0;
    cur_type       = TT_RESET;
    fed            = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Low-res record right after reset: button zero with the proximity bit,
    // which is then dropped because x is below 256.
    send_byte(8'o337);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF & ~8'o200);
    send_byte(8'h7F);

    // Tracker record at full scale whose key is a space.
    program_type(TT_TRACKER);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(KEY_SPACE);
    repeat (14) send_byte(8'h7F);

    // An unused type swallows everything.
    program_type(4'hF);
    send_byte(8'hFF);

    for (int phase = 0; fed < ITEMS; phase++) begin
      if (phase < 16) begin
        t = ttype_t'(phase);
      end else if ($urandom_range(9) == 0) begin
        t = ttype_t'($urandom_range(0, 7));
        if (t != TT_NONE) t = t + 4'd8;
      end else begin
        t = ttype_t'($urandom_range(1, 8));
      end
      program_type(t);
      calm <= (phase >= CALM_FIRST && phase <= CALM_LAST);
      len = int'(rec_len(t));
      sm  = sync_mask(t);
      if (len == 0) begin
        repeat ($urandom_range(2, 6)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        if (phase == SQUEEZE_PHASE) squeeze <= 1'b1;
        nrec = (phase == SQUEEZE_PHASE) ? 60 : $urandom_range(2, 12);
        for (int r = 0; r < nrec; r++) begin
          kind = $urandom_range(99);
          if (kind < 6) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
          end else begin
            // Some records are cut short, some start without a sync bit and
            // rely on the buffer having been full.
            count = (kind < 14) ? $urandom_range(1, len - 1) : len;
            for (int i = 0; i < count; i++)
              send_byte(framed(i, sm, i == 0 && kind >= 20));
          end
        end
        // Leave a partial record behind so the next type starts mid-record.
        if ($urandom_range(1) == 1) begin
          count = $urandom_range(1, len - 1);
          for (int i = 0; i < count; i++) send_byte(framed(i, sm, i == 0));
        end
      end
    end

    settle();
    if (mismatches == 0 && records_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> tablet_record_deframer_decoder_core.f
rtl/trdd_pkg.sv
rtl/trdd_if.sv
rtl/trdd_deframer.sv
rtl/trdd_decoder.sv
rtl/tablet_record_deframer_decoder_core.sv
test/trdd_record_check.sv
test/tb_top.sv
